@@ hdl/cbps_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the cubic bezier polyline sampler
// no dependencies

package cbps_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MAX_STEPS   = 64;
    localparam int T_FRAC      = 16;
    localparam int T_WIDTH     = 17;
    localparam int STEPS_WIDTH = 7;

    localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(65536);

    localparam logic [STEPS_WIDTH-1:0] STEPS_RESET = STEPS_WIDTH'(16);
    localparam logic [T_WIDTH-1:0]     TSTEP_RESET = T_WIDTH'(4096);

    // configuration register indexes
    localparam int CFG_IDX_WIDTH = 4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_STEPS = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TSTEP = CFG_IDX_WIDTH'(1);
    localparam int CFG_DATA_WIDTH = 17;

    // de casteljau lerp sequence
    localparam int OP_WIDTH = 3;
    localparam logic [OP_WIDTH-1:0] OP_L1 = OP_WIDTH'(0);
    localparam logic [OP_WIDTH-1:0] OP_L2 = OP_WIDTH'(1);
    localparam logic [OP_WIDTH-1:0] OP_L3 = OP_WIDTH'(2);
    localparam logic [OP_WIDTH-1:0] OP_L4 = OP_WIDTH'(3);
    localparam logic [OP_WIDTH-1:0] OP_L5 = OP_WIDTH'(4);
    localparam logic [OP_WIDTH-1:0] OP_B  = OP_WIDTH'(5);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_point;

    typedef struct packed {
        logic                          new_curve;
        logic signed [COORD_WIDTH-1:0] knot_x;
        logic signed [COORD_WIDTH-1:0] knot_y;
        logic signed [COORD_WIDTH-1:0] handle_in_x;
        logic signed [COORD_WIDTH-1:0] handle_in_y;
        logic signed [COORD_WIDTH-1:0] handle_out_x;
        logic signed [COORD_WIDTH-1:0] handle_out_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] seg_start_x;
        logic signed [COORD_WIDTH-1:0] seg_start_y;
        logic signed [COORD_WIDTH-1:0] seg_end_x;
        logic signed [COORD_WIDTH-1:0] seg_end_y;
        logic                          last_segment;
    } t_out_item;

endpackage

@@ hdl/cubic_bezier_polyline_sampler.sv @@
`timescale 1ns / 1ps
// cubic bezier polyline sampler, top level: knot store, sample sequencer, output register
// depends on cbps_pkg and cbps_lerp2
// each segment item is worked out in turn by the sequencer, and the output can stall its emit:
//   six 2-d lerps, each a multiply then an add state on the one lerp unit, plus an emit
// a curve-start knot is only held, a drawing knot holds the input until its last segment is emitted
// sync active-low reset clears held knot, sequencer, output valid; 16 steps, t step 4096

module cubic_bezier_polyline_sampler #(
    parameter int MAX_STEPS = cbps_pkg::MAX_STEPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // knot input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  cbps_pkg::t_in_item                    i_in_item,
    // segment output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output cbps_pkg::t_out_item                   o_out_item,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [cbps_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [cbps_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int TW = cbps_pkg::T_WIDTH;
    localparam int AW = TW + 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration
    logic [cbps_pkg::STEPS_WIDTH-1:0] r_cfg_steps;
    logic [TW-1:0]                    r_cfg_tstep;

    // control
    logic [1:0]                     r_state, n_state;
    logic [cbps_pkg::OP_WIDTH-1:0]  r_op, n_op;
    logic [SW-1:0]                  r_j, n_j;
    logic [SW-1:0]                  r_steps, n_steps;
    logic [TW-1:0]                  r_acc, n_acc;
    logic [TW-1:0]                  r_t, n_t;
    logic                           r_have_prev, n_have_prev;
    logic                           r_out_valid, n_out_valid;

    // payload
    cbps_pkg::t_point    r_p0, r_p1, r_p2, r_p3, r_hnext;
    cbps_pkg::t_point    r_l1, r_l2, r_l3, r_l4, r_l5, r_b;
    cbps_pkg::t_point    r_a;
    cbps_pkg::t_out_item r_out;

    cbps_pkg::t_point w_op_a, w_op_b, w_res;
    cbps_pkg::t_point w_knot, w_hin, w_hout;

    logic w_in_acc, w_draw, w_out_free, w_emit, w_emit_last;
    logic w_start_sample;
    logic [SW-1:0] w_j_next, w_steps_eff, w_steps_sel;
    logic [AW-1:0] w_acc_base, w_acc_sum;

    assign w_knot = '{x: i_in_item.knot_x, y: i_in_item.knot_y};
    assign w_hin  = '{x: i_in_item.handle_in_x, y: i_in_item.handle_in_y};
    assign w_hout = '{x: i_in_item.handle_out_x, y: i_in_item.handle_out_y};

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    // a knot draws only when it continues a curve
    assign w_draw      = w_in_acc && !i_in_item.new_curve && r_have_prev;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign w_emit_last = w_emit && (r_j == r_steps);

    // step count clamped to 1..MAX_STEPS
    always_comb begin
        if (r_cfg_steps == '0) begin
            w_steps_eff = SW'(1);
        end else if (int'(r_cfg_steps) > MAX_STEPS) begin
            w_steps_eff = SW'(MAX_STEPS);
        end else begin
            w_steps_eff = SW'(r_cfg_steps);
        end
    end

    // next sample's t: running sum of t_step, saturated at one, forced to one on the last
    assign w_start_sample = w_draw || (w_emit && !w_emit_last);
    assign w_j_next       = w_draw ? SW'(1) : (r_j + SW'(1));
    assign w_steps_sel    = w_draw ? w_steps_eff : r_steps;
    assign w_acc_base     = w_draw ? '0 : AW'(r_acc);
    assign w_acc_sum      = w_acc_base + AW'(r_cfg_tstep);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_j         = r_j;
        n_steps     = r_steps;
        n_acc       = r_acc;
        n_t         = r_t;
        n_have_prev = r_have_prev;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_have_prev = 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_op == cbps_pkg::OP_B) begin
                    n_state = S_EMIT;
                end else begin
                    n_op    = r_op + cbps_pkg::OP_WIDTH'(1);
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    if (w_emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_start_sample) begin
            n_state = S_MUL;
            n_op    = cbps_pkg::OP_L1;
            n_j     = w_j_next;
            n_steps = w_steps_sel;
            if (w_acc_sum > AW'(cbps_pkg::T_ONE)) begin
                n_acc = cbps_pkg::T_ONE;
            end else begin
                n_acc = w_acc_sum[TW-1:0];
            end
            n_t = (w_j_next == w_steps_sel) ? cbps_pkg::T_ONE : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= cbps_pkg::OP_L1;
            r_j         <= '0;
            r_steps     <= '0;
            r_acc       <= '0;
            r_t         <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_steps <= cbps_pkg::STEPS_RESET;
            r_cfg_tstep <= cbps_pkg::TSTEP_RESET;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_j         <= n_j;
            r_steps     <= n_steps;
            r_acc       <= n_acc;
            r_t         <= n_t;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cbps_pkg::REG_STEPS: r_cfg_steps <= i_cfg_data[cbps_pkg::STEPS_WIDTH-1:0];
                    cbps_pkg::REG_TSTEP: r_cfg_tstep <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // held knot: p0/p1 are cleared by reset; the first knot after reset is only held, even without new_curve
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= '0;
            r_p1 <= '0;
        end else if (w_in_acc && !w_draw) begin
            r_p0 <= w_knot;
            r_p1 <= w_hout;
        end else if (w_emit_last) begin
            // this knot becomes the previous one
            r_p0 <= r_p3;
            r_p1 <= r_hnext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_p2    <= w_hin;
            r_p3    <= w_knot;
            r_hnext <= w_hout;
            r_a     <= r_p0;
        end else if (w_emit) begin
            r_a <= r_b;
        end
        if (w_emit) begin
            r_out.seg_start_x  <= r_a.x;
            r_out.seg_start_y  <= r_a.y;
            r_out.seg_end_x    <= r_b.x;
            r_out.seg_end_y    <= r_b.y;
            r_out.last_segment <= (r_j == r_steps);
        end
    end

    // operand select for the lerp unit
    always_comb begin
        case (r_op)
            cbps_pkg::OP_L1: begin
                w_op_a = r_p0;
                w_op_b = r_p1;
            end
            cbps_pkg::OP_L2: begin
                w_op_a = r_p1;
                w_op_b = r_p2;
            end
            cbps_pkg::OP_L3: begin
                w_op_a = r_p2;
                w_op_b = r_p3;
            end
            cbps_pkg::OP_L4: begin
                w_op_a = r_l1;
                w_op_b = r_l2;
            end
            cbps_pkg::OP_L5: begin
                w_op_a = r_l2;
                w_op_b = r_l3;
            end
            default: begin
                w_op_a = r_l4;
                w_op_b = r_l5;
            end
        endcase
    end

    cbps_lerp2 u_lerp (
        .i_clk    (i_clk),
        .i_mul_en (r_state == S_MUL),
        .i_a      (w_op_a),
        .i_b      (w_op_b),
        .i_t      (r_t),
        .o_res    (w_res)
    );

    // lerp result write-back
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            case (r_op)
                cbps_pkg::OP_L1: r_l1 <= w_res;
                cbps_pkg::OP_L2: r_l2 <= w_res;
                cbps_pkg::OP_L3: r_l3 <= w_res;
                cbps_pkg::OP_L4: r_l4 <= w_res;
                cbps_pkg::OP_L5: r_l5 <= w_res;
                default:         r_b  <= w_res;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // t never goes past one
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t <= cbps_pkg::T_ONE) && (r_acc <= cbps_pkg::T_ONE))
        else $error("t above one");

    // sample index stays within the step count while busy
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ((r_j >= SW'(1)) && (r_j <= r_steps)))
        else $error("sample index out of range");

    // the last segment of a knot returns the sequencer to idle with the item flagged
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_last |=> ((r_state == S_IDLE) && o_out_valid && o_out_item.last_segment))
        else $error("last segment did not end the knot");

    // the final sample is always taken at t equal to one
    a_last_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) && (r_j == r_steps)) |-> (r_t == cbps_pkg::T_ONE))
        else $error("final sample not at t one");

endmodule

@@ hdl/cbps_lerp2.sv @@
`timescale 1ns / 1ps
// shared 2-d lerp unit: product registered, then rounding and offset add
// depends on cbps_pkg

module cbps_lerp2 (
    input  logic                               i_clk,
    input  logic                               i_mul_en,
    input  cbps_pkg::t_point                   i_a,
    input  cbps_pkg::t_point                   i_b,
    input  logic [cbps_pkg::T_WIDTH-1:0]       i_t,
    output cbps_pkg::t_point                   o_res
);

    localparam int CW = cbps_pkg::COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = DW + cbps_pkg::T_WIDTH + 1;
    localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (cbps_pkg::T_FRAC - 1);

    logic signed [DW-1:0] w_dx, w_dy;
    logic signed [cbps_pkg::T_WIDTH:0] w_ts;
    logic signed [PW-1:0] w_px, w_py;
    logic signed [PW-1:0] w_sx, w_sy;

    logic signed [PW-1:0] r_px, r_py;
    cbps_pkg::t_point     r_a;

    assign w_dx = $signed({i_b.x[CW-1], i_b.x}) - $signed({i_a.x[CW-1], i_a.x});
    assign w_dy = $signed({i_b.y[CW-1], i_b.y}) - $signed({i_a.y[CW-1], i_a.y});
    assign w_ts = $signed({1'b0, i_t});
    assign w_px = w_dx * w_ts;
    assign w_py = w_dy * w_ts;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_px <= w_px;
            r_py <= w_py;
            r_a  <= i_a;
        end
    end

    // floor((d*t + half) / 2^16); result lies between a and b so it wraps cleanly
    assign w_sx = (r_px + ROUND) >>> cbps_pkg::T_FRAC;
    assign w_sy = (r_py + ROUND) >>> cbps_pkg::T_FRAC;
    assign o_res.x = $signed(r_a.x + w_sx[CW-1:0]);
    assign o_res.y = $signed(r_a.y + w_sy[CW-1:0]);

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for cubic_bezier_polyline_sampler: directed table, then random knots
// depends on cbps_pkg and the sampler rtl; expected segments come from an in-file curve tracer

module testbench;

    // run shape
    localparam int ITEMS_TOTAL    = 480;
    localparam int SETTLE_CYCLES  = 24;        // longer than one segment item takes to compute
    localparam int HOLDOFF_CYCLES = 600;       // long output stall so the block backs up
    localparam int CYCLE_LIMIT    = 5_000_000;
    localparam int PREDICTED      = -1;        // table row checked by the curve tracer

    // a register index past the end of the register list, writes to it are dropped
    localparam logic [cbps_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE = cbps_pkg::CFG_IDX_WIDTH'(9);

    // one row of the directed table: a register write or a knot
    typedef struct {
        bit                                   is_write;
        logic [cbps_pkg::CFG_IDX_WIDTH-1:0]   reg_index;
        logic [cbps_pkg::CFG_DATA_WIDTH-1:0]  reg_data;
        cbps_pkg::t_in_item                   knot;
        int                                   n_typed;    // PREDICTED, or segments typed in
        cbps_pkg::t_out_item                  typed_seg;
    } t_stim_row;

    localparam int N_DIR = 32;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    cbps_pkg::t_in_item                   i_in_item;
    logic                                 o_out_valid;
    logic                                 i_out_ready;
    cbps_pkg::t_out_item                  o_out_item;
    logic                                 i_cfg_we;
    logic [cbps_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index;
    logic [cbps_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data;

    // tracer copy of the block state and its registers
    logic                                          held_valid;
    logic signed [cbps_pkg::COORD_WIDTH-1:0]       held_px, held_py, held_hx, held_hy;
    logic [cbps_pkg::STEPS_WIDTH-1:0]              steps_reg;
    logic [cbps_pkg::T_WIDTH-1:0]                  tstep_reg;

    // segments worked out for the knot just accepted, and all segments still owed
    cbps_pkg::t_out_item        curve_segs[$];
    cbps_pkg::t_out_item        segs_due[$];

    // expectation typed into the table travels with the knot on the input channel
    int                         knot_typed_n;
    cbps_pkg::t_out_item        knot_typed_seg;

    t_stim_row                  dir_rows [N_DIR];
    int                         mismatches;
    int                         knots_sent;
    int                         cycle_count;
    bit                         steady;          // no idling on either side
    int                         holdoff_asks;
    int                         holdoff_done;

    cubic_bezier_polyline_sampler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // curve tracer
    // ---------------------------------------------------------------

    // a + round((b - a) * t), t in q1.16, floor of the biased product
    function automatic longint lerp_q16(input longint a, input longint b, input longint t);
        return a + (((b - a) * t + 32768) >>> 16);
    endfunction

    // fills curve_segs with the segments this knot draws, then keeps the knot
    function automatic void trace_curve(input cbps_pkg::t_in_item k);
        longint p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
        longint l1x, l1y, l2x, l2y, l3x, l3y, l4x, l4y, l5x, l5y;
        longint ax, ay, bx, by, t;
        int n;
        cbps_pkg::t_out_item seg;
        curve_segs.delete();
        // a knot that starts a curve, or the first one ever, is only held
        if (!k.new_curve && held_valid) begin
            p0x = held_px;
            p0y = held_py;
            p1x = held_hx;
            p1y = held_hy;
            p2x = $signed(k.handle_in_x);
            p2y = $signed(k.handle_in_y);
            p3x = $signed(k.knot_x);
            p3y = $signed(k.knot_y);
            // zero steps behave as one, anything past the maximum as the maximum
            if (steps_reg == 0)
                n = 1;
            else if (int'(steps_reg) > cbps_pkg::MAX_STEPS)
                n = cbps_pkg::MAX_STEPS;
            else
                n = int'(steps_reg);
            ax = p0x;
            ay = p0y;
            for (int j = 1; j <= n; j++) begin
                // t saturates at one, and the closing sample always sits at one
                t = longint'(j) * longint'(tstep_reg);
                if (t > longint'(cbps_pkg::T_ONE) || j == n)
                    t = longint'(cbps_pkg::T_ONE);
                l1x = lerp_q16(p0x, p1x, t);
                l1y = lerp_q16(p0y, p1y, t);
                l2x = lerp_q16(p1x, p2x, t);
                l2y = lerp_q16(p1y, p2y, t);
                l3x = lerp_q16(p2x, p3x, t);
                l3y = lerp_q16(p2y, p3y, t);
                l4x = lerp_q16(l1x, l2x, t);
                l4y = lerp_q16(l1y, l2y, t);
                l5x = lerp_q16(l2x, l3x, t);
                l5y = lerp_q16(l2y, l3y, t);
                bx  = lerp_q16(l4x, l5x, t);
                by  = lerp_q16(l4y, l5y, t);
                seg.seg_start_x  = cbps_pkg::COORD_WIDTH'(ax);
                seg.seg_start_y  = cbps_pkg::COORD_WIDTH'(ay);
                seg.seg_end_x    = cbps_pkg::COORD_WIDTH'(bx);
                seg.seg_end_y    = cbps_pkg::COORD_WIDTH'(by);
                seg.last_segment = (j == n);
                curve_segs = {curve_segs, seg};
                ax = bx;
                ay = by;
            end
        end
        held_valid = 1'b1;
        held_px    = k.knot_x;
        held_py    = k.knot_y;
        held_hx    = k.handle_out_x;
        held_hy    = k.handle_out_y;
    endfunction

    // ---------------------------------------------------------------
    // table helpers
    // ---------------------------------------------------------------

    function automatic t_stim_row cfg_row(input logic [cbps_pkg::CFG_IDX_WIDTH-1:0] idx,
                                          input int data);
        t_stim_row r;
        r = '{default: '0};
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_data  = cbps_pkg::CFG_DATA_WIDTH'(data);
        r.n_typed   = PREDICTED;
        return r;
    endfunction

    function automatic t_stim_row knot_row(input bit nc, input int kx, input int ky,
                                           input int ix, input int iy, input int ox,
                                           input int oy, input int n_typed = PREDICTED,
                                           input cbps_pkg::t_out_item seg = '0);
        t_stim_row r;
        r = '{default: '0};
        r.knot.new_curve    = nc;
        r.knot.knot_x       = cbps_pkg::COORD_WIDTH'(kx);
        r.knot.knot_y       = cbps_pkg::COORD_WIDTH'(ky);
        r.knot.handle_in_x  = cbps_pkg::COORD_WIDTH'(ix);
        r.knot.handle_in_y  = cbps_pkg::COORD_WIDTH'(iy);
        r.knot.handle_out_x = cbps_pkg::COORD_WIDTH'(ox);
        r.knot.handle_out_y = cbps_pkg::COORD_WIDTH'(oy);
        r.n_typed           = n_typed;
        r.typed_seg         = seg;
        return r;
    endfunction

    // the one and only segment of a knot, so it is also the last
    function automatic cbps_pkg::t_out_item one_seg(input int sx, input int sy,
                                                    input int ex, input int ey);
        cbps_pkg::t_out_item s;
        s.seg_start_x  = cbps_pkg::COORD_WIDTH'(sx);
        s.seg_start_y  = cbps_pkg::COORD_WIDTH'(sy);
        s.seg_end_x    = cbps_pkg::COORD_WIDTH'(ex);
        s.seg_end_y    = cbps_pkg::COORD_WIDTH'(ey);
        s.last_segment = 1'b1;
        return s;
    endfunction

    function automatic logic [cbps_pkg::COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(9)) inside
            0:       return 16'h8000;
            1:       return 16'h7fff;
            [2:4]:   return cbps_pkg::COORD_WIDTH'($urandom);
            // half the time a spline-sized neighborhood around the origin
            default: return cbps_pkg::COORD_WIDTH'($urandom_range(4000)) - 16'd2000;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // output check first, then the tracer for a knot taken at the same edge;
    // a new knot's segments cannot show up at the edge that accepts it
    always @(posedge i_clk) begin
        cbps_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (segs_due.size() == 0) begin
                    $display("%0t ns: segment item with none expected, expected nothing, actual %h",
                             $time, o_out_item);
                    mismatches++;
                end else begin
                    want = segs_due.pop_front();
                    check_field("seg_start_x", $signed(want.seg_start_x),
                                $signed(o_out_item.seg_start_x));
                    check_field("seg_start_y", $signed(want.seg_start_y),
                                $signed(o_out_item.seg_start_y));
                    check_field("seg_end_x", $signed(want.seg_end_x),
                                $signed(o_out_item.seg_end_x));
                    check_field("seg_end_y", $signed(want.seg_end_y),
                                $signed(o_out_item.seg_end_y));
                    check_field("last_segment", int'(want.last_segment),
                                int'(o_out_item.last_segment));
                end
            end
            if (i_in_valid && o_in_ready) begin
                trace_curve(i_in_item);
                // typed rows stand in for the tracer, which still tracks the held knot
                if (knot_typed_n == PREDICTED)
                    segs_due = {segs_due, curve_segs};
                else if (knot_typed_n == 1)
                    segs_due = {segs_due, knot_typed_seg};
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** cubic_bezier_polyline_sampler: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // output side: random stalls, a calm stretch, and one long hold-off
    // ---------------------------------------------------------------

    initial begin
        int holdoff_left;
        holdoff_left = 0;
        i_out_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_ready <= 1'b0;
            end else if (holdoff_asks != holdoff_done) begin
                holdoff_done++;
                holdoff_left = HOLDOFF_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 25);
            end
        end
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // all waits end at a falling edge, where inputs change
    task automatic wait_idle();
        while (segs_due.size() != 0) @(posedge i_clk);
        // a knot that only starts a curve leaves nothing to wait for, give it time
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic write_reg(input logic [cbps_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [cbps_pkg::CFG_DATA_WIDTH-1:0] data);
        i_in_valid <= 1'b0;
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cbps_pkg::REG_STEPS)
            steps_reg = data[cbps_pkg::STEPS_WIDTH-1:0];
        else if (idx == cbps_pkg::REG_TSTEP)
            tstep_reg = data[cbps_pkg::T_WIDTH-1:0];
    endtask

    // valid stays high across back-to-back items, it is lowered only for a gap
    task automatic send_knot(input cbps_pkg::t_in_item k, input int n_typed,
                             input cbps_pkg::t_out_item seg);
        int gap;
        gap = (steady || $urandom_range(99) >= 25) ? 0 : $urandom_range(1, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_item      <= k;
        knot_typed_n   <= n_typed;
        knot_typed_seg <= seg;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        knots_sent++;
    endtask

    initial begin
        int phase, sel, steps_pick, tstep_pick, n_knots;
        bit big;
        cbps_pkg::t_in_item k;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_item      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        knot_typed_n   = PREDICTED;
        knot_typed_seg = '0;
        mismatches     = 0;
        knots_sent     = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        holdoff_asks   = 0;
        holdoff_done   = 0;
        held_valid     = 1'b0;
        held_px        = '0;
        held_py        = '0;
        held_hx        = '0;
        held_hy        = '0;
        steps_reg      = cbps_pkg::STEPS_RESET;
        tstep_reg      = cbps_pkg::TSTEP_RESET;

        // directed part: extremes, register corners and every special case
        dir_rows = '{
            // first knot after reset is only held
            knot_row(0, 160, -320, 0, 0, 480, -160, 0),
            // reset setting, 16 samples of a real curve
            knot_row(0, 1600, 800, 1200, 1600, 2000, 0),
            // one sample per curve segment: a straight line from knot to knot
            cfg_row(cbps_pkg::REG_STEPS, 1),
            knot_row(0, 32767, -32768, 32767, 32767, -32768, -32768, 1,
                     one_seg(1600, 800, 32767, -32768)),
            knot_row(0, -32768, 32767, 0, 0, 0, 0, 1,
                     one_seg(32767, -32768, -32768, 32767)),
            // new curve flag: held, nothing drawn
            knot_row(1, 0, 0, -32768, -32768, 32767, 32767, 0),
            knot_row(0, 1, -1, 5, 5, -5, -5, 1, one_seg(0, 0, 1, -1)),
            // zero steps act as one
            cfg_row(cbps_pkg::REG_STEPS, 0),
            knot_row(0, -1, 1, 100, 100, 200, 200, 1, one_seg(1, -1, -1, 1)),
            // step count past the maximum acts as the maximum
            cfg_row(cbps_pkg::REG_STEPS, 127),
            cfg_row(cbps_pkg::REG_TSTEP, 1024),
            knot_row(0, 32767, 32767, -32768, 32767, 32767, -32768),
            knot_row(0, -32768, -32768, 32767, -32768, -32768, 32767),
            // zero t step: every sample but the closing one stays on the held knot
            cfg_row(cbps_pkg::REG_STEPS, 4),
            cfg_row(cbps_pkg::REG_TSTEP, 0),
            knot_row(0, 800, -800, 400, 400, -400, 400),
            // largest t step saturates right away
            cfg_row(cbps_pkg::REG_STEPS, 3),
            cfg_row(cbps_pkg::REG_TSTEP, 131071),
            knot_row(0, -4000, 4000, 32767, -32768, 0, 0),
            // t step of exactly one
            cfg_row(cbps_pkg::REG_STEPS, 2),
            cfg_row(cbps_pkg::REG_TSTEP, 65536),
            knot_row(0, 100, 200, 300, 400, 500, 600),
            // write past the register list is dropped, still two steps
            cfg_row(REG_SPARE, 131071),
            knot_row(0, 0, 0, -32768, 32767, 32767, -32768),
            // full step count with an exact t step
            cfg_row(cbps_pkg::REG_STEPS, 64),
            cfg_row(cbps_pkg::REG_TSTEP, 1024),
            knot_row(1, 0, 0, 0, 0, 0, 0, 0),
            knot_row(0, 16, 16, 16, 16, 16, 16),
            // back to the reset setting, largest then smallest coordinate knots
            cfg_row(cbps_pkg::REG_STEPS, 16),
            cfg_row(cbps_pkg::REG_TSTEP, 4096),
            knot_row(1, 32767, 32767, 32767, 32767, 32767, 32767, 0),
            knot_row(0, -32768, -32768, -32768, -32768, -32768, -32768)
        };

        // synchronous reset, released at a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_write)
                write_reg(dir_rows[r].reg_index, dir_rows[r].reg_data);
            else
                send_knot(dir_rows[r].knot, dir_rows[r].n_typed, dir_rows[r].typed_seg);
        end

        // random part: phases of one setting each, mostly well-formed curves
        phase = 0;
        while (knots_sent < ITEMS_TOTAL) begin
            big = 1'b0;
            sel = $urandom_range(19);
            if (sel < 12) begin
                // typical small step counts with the matching t step
                steps_pick = $urandom_range(1, 6);
                tstep_pick = 65536 / steps_pick;
            end else if (sel < 14) begin
                steps_pick = $urandom_range(7, 64);
                tstep_pick = 65536 / steps_pick;
                big = (steps_pick > 16);
            end else if (sel < 16) begin
                // t step that does not match the step count
                steps_pick = $urandom_range(1, 8);
                tstep_pick = $urandom_range(131071);
            end else if (sel < 17) begin
                steps_pick = 0;
                tstep_pick = $urandom_range(131071);
            end else if (sel < 18) begin
                steps_pick = $urandom_range(65, 127);
                tstep_pick = $urandom_range(1024, 131071);
                big = 1'b1;
            end else begin
                steps_pick = $urandom_range(2, 10);
                tstep_pick = $urandom_range(1) ? 0 : 65536 / steps_pick + $urandom_range(64);
            end
            write_reg(cbps_pkg::REG_STEPS, cbps_pkg::CFG_DATA_WIDTH'(steps_pick));
            write_reg(cbps_pkg::REG_TSTEP, cbps_pkg::CFG_DATA_WIDTH'(tstep_pick));

            // one calm phase, and one phase with the output held off
            steady = (phase == 2);
            if (phase == 4)
                holdoff_asks++;

            n_knots = big ? $urandom_range(3, 6) : $urandom_range(12, 28);
            for (int i = 0; i < n_knots; i++) begin
                // each phase opens a curve; a stray new curve flag now and then
                k.new_curve    = (i == 0) || ($urandom_range(99) < 8);
                k.knot_x       = pick_coord();
                k.knot_y       = pick_coord();
                k.handle_in_x  = pick_coord();
                k.handle_in_y  = pick_coord();
                k.handle_out_x = pick_coord();
                k.handle_out_y = pick_coord();
                send_knot(k, PREDICTED, '0);
            end
            phase++;
        end
        steady = 1'b0;

        // drain and let the block settle
        i_in_valid <= 1'b0;
        wait_idle();

        if (mismatches == 0)
            $display("** cubic_bezier_polyline_sampler: PASSED **");
        else
            $display("** cubic_bezier_polyline_sampler: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cbps_pkg.sv
hdl/cbps_lerp2.sv
hdl/cubic_bezier_polyline_sampler.sv
test/testbench.sv
